@@ rtl/trp_pkg.sv @@
// ----------------------------------------------------------------------------
// trp_pkg: shared types and constants of the thermal row packetizer
// Pixel and byte payload structs, the front-to-back job record and the
// constants that several files use.
// ----------------------------------------------------------------------------
package trp_pkg;

    localparam int          PIXELS_PER_ROW_DEF = 32;
    localparam int          QUEUE_DEPTH        = 4;
    localparam logic [7:0]  MARKER_RESET       = 8'hFE;
    localparam logic [7:0]  CRC_POLY           = 8'h8C;
    // x / 5 == (x * 0xCCCD) >> 18 for any 16-bit x
    localparam logic [15:0] RECIP_5            = 16'hCCCD;
    localparam int          RECIP_SHIFT        = 18;

    typedef struct packed {
        logic signed [15:0] pixel_value;
        logic [7:0]         row_id;
        logic [7:0]         sequence_number;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic       range_error;
    } t_byte_out;

    // one unit of work for the back end: header, one data group, CRC, or a mix
    typedef struct packed {
        logic        hdr;
        logic        grp;
        logic        last;
        logic [7:0]  row_id;
        logic [7:0]  seq;
        logic [39:0] word;
        logic        err;
    } t_job;

    typedef struct packed {
        logic                             empty;
        logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
    } t_q_stat;

endpackage

@@ rtl/trp_front.sv @@
// ----------------------------------------------------------------------------
// trp_front: pixel intake, divide by five and group packing
// Stage one registers the reciprocal product; stage two extracts the
// quotient, packs four 10-bit values into a 40-bit word and posts jobs.
// ----------------------------------------------------------------------------
module trp_front #(
    parameter int PIXELS_PER_ROW = trp_pkg::PIXELS_PER_ROW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  trp_pkg::t_pix_in i_in_data,
    input  trp_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output trp_pkg::t_job    o_job
);
    import trp_pkg::*;

    localparam int PW = $clog2(PIXELS_PER_ROW);

    logic        accept;
    logic        neg;
    logic [15:0] raw;
    logic [15:0] mag;

    logic        r_m_valid;
    logic [31:0] r_prod;
    logic        r_neg;
    logic [7:0]  r_row;
    logic [7:0]  r_seq;

    logic [PW-1:0] r_pos;
    logic [29:0]   r_pend;
    logic          r_gerr;

    logic [12:0] qm;
    logic [12:0] qm_neg;
    logic [9:0]  q10;
    logic        err;
    logic        pos_first;
    logic        pos_last;
    logic        grp_end;
    logic [39:0] w40;
    logic [39:0] word;

    // room is reserved for the item already in the multiply stage
    assign o_in_stall = ($clog2(QUEUE_DEPTH+2))'(i_q_stat.count) +
                        ($clog2(QUEUE_DEPTH+2))'(r_m_valid) >=
                        ($clog2(QUEUE_DEPTH+2))'(QUEUE_DEPTH);
    assign accept = i_in_valid && !o_in_stall;

    assign raw = i_in_data.pixel_value;
    assign neg = raw[15];
    assign mag = neg ? (~raw + 16'd1) : raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= accept;
        end
        if (accept) begin
            r_prod <= 32'(mag) * 32'(RECIP_5);
            r_neg  <= neg;
            r_row  <= i_in_data.row_id;
            r_seq  <= i_in_data.sequence_number;
        end
    end

    assign qm     = r_prod[RECIP_SHIFT +: 13];
    assign qm_neg = 13'd0 - qm;
    assign q10    = r_neg ? qm_neg[9:0] : qm[9:0];
    assign err    = (r_neg && qm != 13'd0) || (qm[12:10] != 3'd0);

    assign pos_first = r_pos == '0;
    assign pos_last  = r_pos == PW'(PIXELS_PER_ROW - 1);
    assign grp_end   = (r_pos[1:0] == 2'd3) || pos_last;

    // a short group is padded with zero values at the tail
    assign w40 = {r_pend, q10};
    always_comb begin
        case (r_pos[1:0])
            2'd0:    word = w40 << 30;
            2'd1:    word = w40 << 20;
            2'd2:    word = w40 << 10;
            default: word = w40;
        endcase
    end

    assign o_push     = r_m_valid && (pos_first || grp_end);
    assign o_job.hdr  = pos_first;
    assign o_job.grp  = grp_end;
    assign o_job.last = pos_last;
    assign o_job.row_id = r_row;
    assign o_job.seq  = r_seq;
    assign o_job.word = word;
    assign o_job.err  = r_gerr | err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_pend <= '0;
            r_gerr <= 1'b0;
        end else if (r_m_valid) begin
            r_pos <= pos_last ? '0 : r_pos + PW'(1);
            if (grp_end) begin
                r_pend <= '0;
                r_gerr <= 1'b0;
            end else begin
                r_pend <= {r_pend[19:0], q10};
                r_gerr <= r_gerr | err;
            end
        end
    end

endmodule

@@ rtl/trp_queue.sv @@
// ----------------------------------------------------------------------------
// trp_queue: short job queue between front and back
// Flop-based FIFO, head visible combinationally, one push and one pop a cycle.
// ----------------------------------------------------------------------------
module trp_queue #(
    parameter int DEPTH = trp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  trp_pkg::t_job    i_job,
    input  logic             i_pop,
    output trp_pkg::t_job    o_head,
    output trp_pkg::t_q_stat o_stat
);
    import trp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = r_count == '0;
    assign o_stat.count = r_count;

endmodule

@@ rtl/trp_back.sv @@
// ----------------------------------------------------------------------------
// trp_back: byte sequencer with running CRC-8
// Walks each job through the header, data and CRC bytes that it carries, one
// byte a cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module trp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trp_pkg::t_job      i_head,
    input  trp_pkg::t_q_stat   i_q_stat,
    output logic               o_pop,
    input  logic [7:0]         i_start_marker,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output trp_pkg::t_byte_out o_out_data
);
    import trp_pkg::*;

    typedef enum logic [3:0] {
        ST_MARKER, ST_ROW, ST_SEQ, ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_CRC
    } t_step;

    function automatic logic [7:0] crc8_upd(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] d;
        r = c;
        d = b;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ d[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
            d = d >> 1;
        end
        return r;
    endfunction

    logic      r_busy;
    t_job      r_job;
    t_step     r_step;
    logic [7:0] r_crc;
    logic      r_out_valid;
    t_byte_out r_out_data;

    logic      out_free;
    logic      emit;
    logic      fin;
    t_step     n_step;
    t_step     first_step;
    t_byte_out cur;
    logic [7:0] crc_in;

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = r_busy && out_free;

    always_comb begin
        fin    = 1'b0;
        n_step = r_step;
        unique case (r_step)
            ST_SEQ: begin
                if (r_job.grp) begin
                    n_step = ST_D0;
                end else if (r_job.last) begin
                    n_step = ST_CRC;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_D4: begin
                if (r_job.last) begin
                    n_step = ST_CRC;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_CRC:  fin = 1'b1;
            default: n_step = t_step'(r_step + 4'd1);
        endcase
    end

    always_comb begin
        if (i_head.hdr) begin
            first_step = ST_MARKER;
        end else if (i_head.grp) begin
            first_step = ST_D0;
        end else begin
            first_step = ST_CRC;
        end
    end

    always_comb begin
        cur.is_last     = 1'b0;
        cur.range_error = 1'b0;
        unique case (r_step)
            ST_MARKER: cur.out_byte = i_start_marker;
            ST_ROW:    cur.out_byte = r_job.row_id;
            ST_SEQ:    cur.out_byte = r_job.seq;
            ST_D0:     cur.out_byte = r_job.word[39:32];
            ST_D1:     cur.out_byte = r_job.word[31:24];
            ST_D2:     cur.out_byte = r_job.word[23:16];
            ST_D3:     cur.out_byte = r_job.word[15:8];
            ST_D4:     cur.out_byte = r_job.word[7:0];
            ST_CRC: begin
                cur.out_byte = r_crc;
                cur.is_last  = 1'b1;
            end
            default:   cur.out_byte = '0;
        endcase
        if (r_step inside {ST_D0, ST_D1, ST_D2, ST_D3, ST_D4}) begin
            cur.range_error = r_job.err;
        end
    end

    assign crc_in = (r_step == ST_MARKER) ? 8'd0 : r_crc;
    assign o_pop  = !i_q_stat.empty && (!r_busy || (emit && fin));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= ST_MARKER;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_job  <= i_head;
                r_step <= first_step;
            end else if (emit) begin
                r_busy <= !fin;
                r_step <= n_step;
            end
            if (emit) begin
                r_out_data <= cur;
                r_crc      <= (r_step == ST_CRC) ? 8'd0 : crc8_upd(crc_in, cur.out_byte);
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/thermal_row_packetizer.sv @@
// ----------------------------------------------------------------------------
// thermal_row_packetizer: thermal pixel row to CRC-8 framed byte stream
// Divides each pixel by five, packs 10-bit values four to five bytes and
// frames each row with a marker, row id, sequence byte and CRC-8.
// ----------------------------------------------------------------------------
// The front end takes one pixel per cycle while its four-entry job queue has
// room; a pixel's job is pushed after the multiply stage and, with the byte
// sequencer idle, popped and its first byte registered at the output. The
// byte sequencer sets the sustained rate: one output byte per cycle while the
// output is not stalled. Each row makes 4 + 5*ceil(PIXELS_PER_ROW/4) bytes
// (44 for 32 pixels), and the input stalls whenever the queue fills. row_id
// and sequence_number are taken from the row's first pixel. start_marker may
// only be written while no packet is in progress.
module thermal_row_packetizer #(
    parameter int PIXELS_PER_ROW = trp_pkg::PIXELS_PER_ROW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  trp_pkg::t_pix_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output trp_pkg::t_byte_out o_out_data,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data
);
    import trp_pkg::*;

    logic [7:0] r_start_marker;
    logic       push;
    logic       pop;
    t_job       job;
    t_job       head;
    t_q_stat    q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= MARKER_RESET;
        end else if (i_cfg_we) begin
            r_start_marker <= i_cfg_data;
        end
    end

    trp_front #(
        .PIXELS_PER_ROW(PIXELS_PER_ROW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (job)
    );

    trp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    trp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .i_start_marker (r_start_marker),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

    // queue bookkeeping
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |-> q_stat.count < ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH) |-> o_in_stall)
        else $error("input open while queue full");

    // CRC byte never carries a range flag
    a_last_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_last |-> !o_out_data.range_error)
        else $error("range flag on CRC byte");

endmodule
